FILE: design/sbf_pkg.sv
// Package for the separable box filter: status codes, configuration
// register indexes and fixed field widths.
// No dependencies.
package sbf_pkg;

  // Fixed widths of the configuration registers.
  localparam int KBits   = 4;
  localparam int FwBits  = 11;
  localparam int FhBits  = 13;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 13;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BADK  = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

endpackage

FILE: design/sbf_ifs.sv
// Handshake interfaces of the separable box filter: pixel input, pixel
// output and configuration write channel. Depends on sbf_pkg.
interface sbf_pix_in_if #(parameter int PixelBits = 8) ();
  logic                 valid;
  logic                 ready;
  logic [PixelBits-1:0] pixel_in;
  logic                 is_flush;
  modport source (output valid, pixel_in, is_flush, input ready);
  modport sink   (input valid, pixel_in, is_flush, output ready);
endinterface

interface sbf_pix_out_if #(parameter int PixelBits = 8) ();
  logic                 valid;
  logic                 ready;
  logic [PixelBits-1:0] pixel_out;
  logic                 last_of_run;
  logic                 frame_end;
  logic [1:0]           status;
  modport source (output valid, pixel_out, last_of_run, frame_end, status, input ready);
  modport sink   (input valid, pixel_out, last_of_run, frame_end, status, output ready);
endinterface

interface sbf_cfg_if import sbf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/separable_box_filter_2d_unit.sv
// Separable K x K box filter on a raster pixel stream; depends on sbf_pkg and sbf_ifs.
// Row averages go through a line store and a column-sum store, both synchronous memories.
//
// Each pixel item is taken when the block is idle and handled by a sequence of states.
// A row-window sum is divided by K in a shared one-bit-per-cycle divider, then the
// column-sum and line stores are read and written back (skipped when K is 1), then
// the column sum is divided by K again and the result goes to the output register.
// In the rows above the first output row the column division is skipped and no
// result is sent. The last pixel of a row also finishes K/2 border columns, each
// with its own row division and the steps after it. An item that finishes no
// column goes straight to the end of its handling, and an error result goes
// straight to the output register. The divider sets the pace.
// Results leave through one output register, so the block keeps working while
// a result waits. A configuration write is taken only while the block is idle,
// and a write to any index but CFG_NONE restarts the frame. Send K/2 rows of
// flush items after each frame to drain the last rows. No clearing pass: data
// read from a store is used only where it was written earlier in the frame.
module separable_box_filter_2d_unit
  import sbf_pkg::*;
#(
  parameter int PIXEL_BITS = 8,
  parameter int MAX_KERNEL = 15,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbf_pix_in_if.sink    pix_in,
  sbf_pix_out_if.source pix_out,
  sbf_cfg_if.sink       cfg
);

  localparam int P      = PIXEL_BITS;
  localparam int SW     = PIXEL_BITS + KBits;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + MAX_KERNEL);
  localparam int PHW    = $clog2(MAX_KERNEL);
  localparam int SLOTS  = MAX_KERNEL - 1;
  localparam int SLW    = $clog2(SLOTS);
  localparam int LDEPTH = SLOTS * (2 ** XW);
  localparam int DCW    = $clog2(PIXEL_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_BORD, S_RDIV, S_MEMRD, S_MEMWB, S_POST, S_CDIV, S_EMIT, S_NEXT, S_FIN
  } state_e;

  state_e            state_q;
  logic [KBits-1:0]  k_q;
  logic [FwBits-1:0] fw_q;
  logic [FhBits-1:0] fh_q;
  logic [CW-1:0]     c_q;
  logic [RW-1:0]     r_q;
  logic [PHW-1:0]    ph_q, bph_q;
  logic [SLW-1:0]    slot_q;
  logic [SW-1:0]     rowsum_q, sum_q, total_q;
  logic [P-1:0]      win_q [MAX_KERNEL];
  logic [XW-1:0]     x_q;
  logic              border_q, err_q;
  logic [KBits-1:0]  bi_q;
  logic [P-1:0]      avg_q;
  logic [KBits-1:0]  div_rem_q;
  logic [P-1:0]      div_lo_q;
  logic [DCW-1:0]    div_cnt_q;
  logic [P-1:0]      res_pix_q;
  logic              res_last_q, res_fend_q;
  status_e           res_st_q;
  logic              out_valid_q;
  logic [P-1:0]      out_pix_q;
  logic              out_last_q, out_fend_q;
  status_e           out_st_q;

  // Stores: line store of row averages and per-column running sums.
  logic [P-1:0]  line_mem [LDEPTH];
  logic [SW-1:0] cs_mem [MAX_WIDTH];
  logic [P-1:0]  ln_rd_q;
  logic [SW-1:0] cs_rd_q;

  // Effective frame size and kernel checks.
  logic [CW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [KBits-1:0] b;
  logic             empty, badk;
  assign w_eff = (int'(fw_q) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(fw_q);
  assign h_eff = (int'(fh_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fh_q);
  assign b     = k_q >> 1;
  assign empty = (w_eff == '0) || (h_eff == '0);
  assign badk  = (k_q == '0) || !k_q[0] || (int'(k_q) > MAX_KERNEL) ||
                 (int'(k_q) > int'(w_eff)) || (int'(k_q) > int'(h_eff));

  // Position of the incoming pixel after a wrap on a stale position.
  logic           wrap;
  logic [CW-1:0]  nc;
  logic [RW-1:0]  nr;
  logic [PHW-1:0] nph;
  logic [SLW-1:0] nslot;
  logic [P-1:0]   pix, win_drop;
  logic [SW-1:0]  new_sum;
  assign wrap  = (int'(c_q) >= int'(w_eff)) || (int'(r_q) >= int'(h_eff) + int'(b));
  assign nc    = wrap ? '0 : c_q;
  assign nr    = wrap ? '0 : r_q;
  assign nph   = wrap ? '0 : ph_q;
  assign nslot = wrap ? '0 : slot_q;
  assign pix   = (pix_in.is_flush || int'(nr) >= int'(h_eff)) ? '0 : pix_in.pixel_in;
  assign win_drop = (int'(nc) >= int'(k_q)) ? win_q[nph] : '0;
  assign new_sum  = ((nc == '0) ? SW'(0) : rowsum_q) + SW'(pix) - SW'(win_drop);

  // Border columns at row end walk the window onward.
  logic [PHW-1:0] bph_n;
  logic [SW-1:0]  bsum;
  assign bph_n = (int'(bph_q) == int'(k_q) - 1) ? '0 : PHW'(bph_q + 1'b1);
  assign bsum  = sum_q - SW'(win_q[bph_n]);

  // One restoring division step.
  logic [KBits:0]   trial;
  logic             ge;
  logic [KBits-1:0] rem_n;
  logic [P-1:0]     lo_n;
  assign trial = {div_rem_q, div_lo_q[P-1]};
  assign ge    = trial >= {1'b0, k_q};
  assign rem_n = ge ? KBits'(trial - {1'b0, k_q}) : KBits'(trial);
  assign lo_n  = {div_lo_q[P-2:0], ge};
  logic div_done;
  assign div_done = (int'(div_cnt_q) == P - 1);

  // Column update from the store read data.
  logic [SW-1:0] col_total, col_wr;
  logic [SW-1:0] col_old;
  logic [P-1:0]  col_drop;
  assign col_old   = (r_q == '0) ? '0 : cs_rd_q;
  assign col_drop  = (int'(r_q) >= int'(k_q) - 1) ? ln_rd_q : '0;
  assign col_total = col_old + SW'(avg_q);
  assign col_wr    = col_total - SW'(col_drop);

  // Whether another column follows for this item.
  logic more;
  assign more = border_q ? (bi_q != b - 1'b1)
                         : ((int'(c_q) == int'(w_eff) - 1) && (b != '0));

  logic out_free;
  assign out_free = !out_valid_q || pix_out.ready;

  // The output register is loaded in this cycle.
  logic emit_fire;
  assign emit_fire = (state_q == S_EMIT) && out_free;

  // A configuration write goes first when both channels are offered while idle.
  assign pix_in.ready = (state_q == S_IDLE) && !cfg.valid;
  assign cfg.ready    = (state_q == S_IDLE);

  // Memory ports: read in S_MEMRD, written back in S_MEMWB.
  always_ff @(posedge clk_i) begin
    if (state_q == S_MEMRD) begin
      cs_rd_q <= cs_mem[x_q];
      ln_rd_q <= line_mem[{slot_q, x_q}];
    end
    if (state_q == S_MEMWB) begin
      cs_mem[x_q]               <= col_wr;
      line_mem[{slot_q, x_q}]   <= avg_q;
    end
  end

  // Sequencer with configuration, position, divider and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= KBits'(3);
      fw_q        <= FwBits'(640);
      fh_q        <= FhBits'(480);
      c_q         <= '0;
      r_q         <= '0;
      ph_q        <= '0;
      slot_q      <= '0;
      rowsum_q    <= '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        win_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      border_q    <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      if (out_valid_q && pix_out.ready && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_idx_e'(cfg.index))
          CFG_KERNEL: k_q  <= cfg.data[KBits-1:0];
          CFG_WIDTH:  fw_q <= cfg.data[FwBits-1:0];
          CFG_HEIGHT: fh_q <= cfg.data[FhBits-1:0];
          default: ;
        endcase
        if (cfg_idx_e'(cfg.index) != CFG_NONE) begin
          c_q      <= '0;
          r_q      <= '0;
          ph_q     <= '0;
          slot_q   <= '0;
          rowsum_q <= '0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (pix_in.valid && !cfg.valid) begin
            if (empty || badk) begin
              res_pix_q  <= '0;
              res_last_q <= 1'b1;
              res_fend_q <= 1'b0;
              res_st_q   <= empty ? ST_EMPTY : ST_BADK;
              err_q      <= 1'b1;
              state_q    <= S_EMIT;
            end else begin
              err_q       <= 1'b0;
              c_q         <= nc;
              r_q         <= nr;
              ph_q        <= nph;
              slot_q      <= nslot;
              win_q[nph]  <= pix;
              sum_q       <= new_sum;
              border_q    <= 1'b0;
              res_st_q    <= ST_OK;
              if (int'(nc) >= int'(b)) begin
                x_q       <= XW'(int'(nc) - int'(b));
                div_rem_q <= new_sum[SW-1:P];
                div_lo_q  <= new_sum[P-1:0];
                div_cnt_q <= '0;
                state_q   <= S_RDIV;
              end else begin
                state_q <= S_FIN;
              end
            end
          end
        end
        S_BORD: begin
          bph_q     <= bph_n;
          sum_q     <= bsum;
          x_q       <= XW'(int'(w_eff) - int'(b) + int'(bi_q));
          div_rem_q <= bsum[SW-1:P];
          div_lo_q  <= bsum[P-1:0];
          div_cnt_q <= '0;
          state_q   <= S_RDIV;
        end
        S_RDIV: begin
          div_rem_q <= rem_n;
          div_lo_q  <= lo_n;
          div_cnt_q <= DCW'(div_cnt_q + 1'b1);
          if (div_done) begin
            avg_q <= lo_n;
            if (k_q == KBits'(1)) begin
              total_q <= SW'(lo_n);
              state_q <= S_POST;
            end else begin
              state_q <= S_MEMRD;
            end
          end
        end
        S_MEMRD: state_q <= S_MEMWB;
        S_MEMWB: begin
          total_q <= col_total;
          state_q <= S_POST;
        end
        S_POST: begin
          if (int'(r_q) >= int'(b)) begin
            div_rem_q <= total_q[SW-1:P];
            div_lo_q  <= total_q[P-1:0];
            div_cnt_q <= '0;
            state_q   <= S_CDIV;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_CDIV: begin
          div_rem_q <= rem_n;
          div_lo_q  <= lo_n;
          div_cnt_q <= DCW'(div_cnt_q + 1'b1);
          if (div_done) begin
            res_pix_q  <= lo_n;
            res_last_q <= !more;
            res_fend_q <= (int'(r_q) == int'(h_eff) - 1 + int'(b)) &&
                          (int'(x_q) == int'(w_eff) - 1);
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= res_pix_q;
            out_last_q  <= res_last_q;
            out_fend_q  <= res_fend_q;
            out_st_q    <= res_st_q;
            state_q     <= err_q ? S_IDLE : S_NEXT;
          end
        end
        S_NEXT: begin
          if (more) begin
            if (border_q) begin
              bi_q <= KBits'(bi_q + 1'b1);
            end else begin
              border_q <= 1'b1;
              bi_q     <= '0;
              bph_q    <= ph_q;
            end
            state_q <= S_BORD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          rowsum_q <= sum_q;
          if (int'(c_q) + 1 >= int'(w_eff)) begin
            c_q  <= '0;
            ph_q <= '0;
            if (int'(r_q) + 1 >= int'(h_eff) + int'(b)) begin
              r_q    <= '0;
              slot_q <= '0;
            end else begin
              r_q    <= RW'(r_q + 1'b1);
              slot_q <= (int'(slot_q) >= int'(k_q) - 2) ? '0 : SLW'(slot_q + 1'b1);
            end
          end else begin
            c_q  <= CW'(c_q + 1'b1);
            ph_q <= (int'(ph_q) == int'(k_q) - 1) ? '0 : PHW'(ph_q + 1'b1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pix_out.valid       = out_valid_q;
  assign pix_out.pixel_out   = out_pix_q;
  assign pix_out.last_of_run = out_last_q;
  assign pix_out.frame_end   = out_fend_q;
  assign pix_out.status      = out_st_q;

endmodule
